// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/srl_pkg.sv =====
package srl_pkg;

    // store geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 11;
    localparam int VAL_W    = 32;

    // operation codes carried in tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // latch a new input beat
        logic clear;     // empty the store
        logic rd_en;     // read the store
        logic rd_mid;    // read address is the search midpoint
        logic rd_next;   // read address is ptr - 2 instead of ptr - 1
        logic mid_load;  // register the search midpoint
        logic cmp_step;  // narrow the search window
        logic wr_en;     // write the store at ptr
        logic wr_shift;  // write data is the entry read, not the key
        logic ptr_dec;   // move the insert pointer down
        logic count_inc; // one more value stored
        logic res_load;  // load the output beat register
    } srl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_full;
        logic ptr_zero;
        logic ptr_one;
        logic rd_gt;
        logic search_done;
        logic out_busy;
    } srl_sts_t;

endpackage

// ===== hw/rtl/srl_ctrl.sv =====
`include "assert_macros.svh"

module srl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       op,
    output srl_pkg::srl_cmd_t cmd,
    input  srl_pkg::srl_sts_t sts
);
    import srl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_Q_RD    = 6'b000010,
        ST_Q_CMP   = 6'b000100,
        ST_L_RD    = 6'b001000,
        ST_L_SHIFT = 6'b010000,
        ST_RES     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    case (op)
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_LOAD:  state_next = sts.count_full ? ST_RES : ST_L_RD;
                        OP_QUERY: state_next = ST_Q_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_Q_RD:
            begin
                if (sts.search_done)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_mid   = 1'b1;
                    cmd.mid_load = 1'b1;
                    state_next   = ST_Q_CMP;
                end
            end
            ST_Q_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = ST_Q_RD;
            end
            ST_L_RD:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.count_inc = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_L_SHIFT;
                end
            end
            ST_L_SHIFT:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.ptr_dec  = 1'b1;
                    if (sts.ptr_one)
                    begin
                        state_next = ST_L_RD;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.count_inc = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RES:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a search step always follows a midpoint read
    `ASSERT_NEXT(a_mid_then_cmp, clk, rst_n, cmd.mid_load, state_reg == ST_Q_CMP)
    // the store is never grown when already full
    `ASSERT_IMPLIES(a_no_grow_full, clk, rst_n, cmd.count_inc, !sts.count_full)

endmodule

// ===== hw/rtl/srl_datapath.sv =====
`include "assert_macros.svh"

module srl_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       s_tdata,  // value[31:0]
    input  logic [1:0]        s_tuser,  // operation[1:0]
    input  srl_pkg::srl_cmd_t cmd,
    output srl_pkg::srl_sts_t sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata   // found[0], position[11:1], full_res[12], zero[15:13]
);
    import srl_pkg::*;

    // sorted value store
    logic signed [VAL_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] key_reg;
    logic signed [VAL_W-1:0] rdata_reg;
    logic [CNT_W-1:0]        lo_reg;
    logic [CNT_W-1:0]        hi_reg;
    logic [CNT_W-1:0]        ptr_reg;
    logic [ADDR_W-1:0]       mid_reg;
    logic                    eq_reg;
    logic                    full_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    found_reg;
    logic                    full_res_reg;

    logic [CNT_W:0]          mid_sum;
    logic [ADDR_W-1:0]       mid_next;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [CNT_W:0]          pos_sum;

    // address and data selection
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next = ADDR_W'(mid_sum >> 1);
    assign rd_addr  = cmd.rd_mid  ? mid_next :
                      cmd.rd_next ? ADDR_W'(ptr_reg - CNT_W'(2)) :
                                    ADDR_W'(ptr_reg - CNT_W'(1));
    assign wr_addr  = ADDR_W'(ptr_reg);
    assign wr_data  = cmd.wr_shift ? rdata_reg : key_reg;
    assign pos_sum  = {1'b0, lo_reg} + (CNT_W + 1)'(1);

    // status back to the controller
    assign sts.count_full  = (count_reg >= CNT_W'(CAPACITY));
    assign sts.ptr_zero    = (ptr_reg == '0);
    assign sts.ptr_one     = (ptr_reg == CNT_W'(1));
    assign sts.rd_gt       = (rdata_reg > key_reg);
    assign sts.search_done = (lo_reg >= hi_reg);
    assign sts.out_busy    = out_valid_reg && !m_tready;

    // store port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // fill count and output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // search window, insert pointer and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg  <= s_tdata;
            lo_reg   <= '0;
            hi_reg   <= count_reg;
            ptr_reg  <= count_reg;
            eq_reg   <= 1'b0;
            full_reg <= (s_tuser == OP_LOAD);
        end
        if (cmd.mid_load)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.cmp_step)
        begin
            if (rdata_reg < key_reg)
            begin
                lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
            end
            else
            begin
                hi_reg <= CNT_W'(mid_reg);
                eq_reg <= (rdata_reg == key_reg);
            end
        end
        if (cmd.ptr_dec)
        begin
            ptr_reg <= ptr_reg - CNT_W'(1);
        end
        if (cmd.res_load)
        begin
            found_reg    <= eq_reg;
            pos_reg      <= eq_reg ? POS_W'(pos_sum) : '0;
            full_res_reg <= full_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, full_res_reg, pos_reg, found_reg};

    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_IMPLIES(a_res_slot_free, clk, rst_n, cmd.res_load, !(out_valid_reg && !m_tready))
    `ASSERT_IMPLIES(a_search_open, clk, rst_n, cmd.cmp_step, lo_reg < hi_reg)
    `ASSERT_IMPLIES(a_write_in_range, clk, rst_n, cmd.wr_en, ptr_reg <= count_reg)

endmodule

// ===== hw/rtl/sorted_rank_lookup.sv =====
// a query does a midpoint read and then a compare for each search step, with at most
// floor(log2(count)) + 1 search steps, then loads the output register; a load into a full
// store is dropped and goes straight to the output register; one beat in flight; a load
// shifts each stored value above the new one up one place, reading the next while writing the last
// a finished result waits in the output register while the next beat is taken; a later result
// stalls until that register is free
// reset: fill count and control cleared; store contents undefined, no clearing pass
module sorted_rank_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value[31:0]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // found[0], position[11:1], full_res[12], zero[15:13]
);
    import srl_pkg::*;

    srl_cmd_t cmd;
    srl_sts_t sts;

    // sequencer
    srl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // store, search window and output beat
    srl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
